// File: rtl/core/apib_pkg.sv
// Shared types and constants for the adaptive poll interval backoff unit.
package apib_pkg;

	localparam int THR_W      = 16;
	localparam int FACTOR_W   = 12;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CUR_W      = 16;
	localparam int INTV_W     = 13;
	localparam int STABLE_W   = 3;
	localparam int FRAC_W     = 8;
	localparam int PROD_W     = INTV_W + FACTOR_W;

	localparam logic [INTV_W-1:0]    FAST_MS         = 13'd200;
	localparam logic [INTV_W-1:0]    SLOW_MS         = 13'd5000;
	localparam logic [INTV_W-1:0]    ELAPSED_MAX     = 13'd8191;
	localparam logic [STABLE_W-1:0]  STABLE_SAMPLES  = 3'd5;
	localparam logic [THR_W-1:0]     THR_RESET       = 16'd50;
	localparam logic [FACTOR_W-1:0]  FACTOR_RESET    = 12'd512;

	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FACTOR    = 1'd1;

	typedef enum logic [1:0] {
		ACT_TICK    = 2'd0,
		ACT_CURRENT = 2'd1,
		ACT_STATUS  = 2'd2,
		ACT_FORCE   = 2'd3
	} action_t;

	typedef struct packed {
		logic [THR_W-1:0]    threshold;
		logic [FACTOR_W-1:0] factor;
	} cfg_t;

	typedef struct packed {
		action_t           action;
		logic [CUR_W-1:0]  current_ma;
		logic              fast_charge_on;
		logic              path_one_online;
		logic              path_two_online;
	} item_t;

	typedef struct packed {
		logic              scan_due;
		logic [INTV_W-1:0] interval_ms;
	} result_t;

endpackage

// File: rtl/core/apib_cfg.sv
// Configuration register file: change threshold and backoff factor.
module apib_cfg
	import apib_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	logic [THR_W-1:0]    threshold_q;
	logic [FACTOR_W-1:0] factor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THR_RESET;
			factor_q    <= FACTOR_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_THRESHOLD: threshold_q <= cfg_data[THR_W-1:0];
				CFG_FACTOR:    factor_q    <= cfg_data[FACTOR_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.threshold = threshold_q;
	assign cfg.factor    = factor_q;

endmodule

// File: rtl/core/apib_sched.sv
// Scheduler state and next-state logic: tick count, change detection, backoff.
module apib_sched
	import apib_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t result
);

	logic [INTV_W-1:0]   interval_q;
	logic [INTV_W-1:0]   elapsed_q;
	logic [STABLE_W-1:0] stable_q;
	logic [CUR_W-1:0]    prev_cur_q;
	logic                prev_fc_q;
	logic                prev_p1_q;
	logic                prev_p2_q;

	logic [INTV_W-1:0]   interval_d;
	logic [INTV_W-1:0]   elapsed_d;
	logic [STABLE_W-1:0] stable_d;
	logic [CUR_W-1:0]    prev_cur_d;
	logic                prev_fc_d;
	logic                prev_p1_d;
	logic                prev_p2_d;
	logic                due;

	logic [INTV_W-1:0]   elapsed_inc;
	logic [CUR_W-1:0]    cur;
	logic [CUR_W-1:0]    diff;
	logic [STABLE_W-1:0] stable_inc;
	logic [PROD_W-1:0]   prod;
	logic [PROD_W-FRAC_W-1:0] scaled;
	logic [INTV_W-1:0]   backoff;
	logic                status_changed;

	always_comb begin
		elapsed_inc = (elapsed_q < ELAPSED_MAX) ? elapsed_q + 1'b1 : elapsed_q;
		cur         = item.current_ma[CUR_W-1] ? '0 : item.current_ma;
		diff        = (cur > prev_cur_q) ? cur - prev_cur_q : prev_cur_q - cur;
		stable_inc  = stable_q + 1'b1;
		prod        = PROD_W'(interval_q) * PROD_W'(cfg.factor);
		scaled      = prod[PROD_W-1:FRAC_W];
		if (scaled < (PROD_W-FRAC_W)'(FAST_MS)) begin
			backoff = FAST_MS;
		end else if (scaled > (PROD_W-FRAC_W)'(SLOW_MS)) begin
			backoff = SLOW_MS;
		end else begin
			backoff = scaled[INTV_W-1:0];
		end
		status_changed = (item.fast_charge_on != prev_fc_q) ||
			(item.path_one_online != prev_p1_q) || (item.path_two_online != prev_p2_q);

		interval_d = interval_q;
		elapsed_d  = elapsed_q;
		stable_d   = stable_q;
		prev_cur_d = prev_cur_q;
		prev_fc_d  = prev_fc_q;
		prev_p1_d  = prev_p1_q;
		prev_p2_d  = prev_p2_q;
		due        = 1'b0;

		case (item.action)
			ACT_TICK: begin
				if (elapsed_inc >= interval_q) begin
					due       = 1'b1;
					elapsed_d = '0;
				end else begin
					elapsed_d = elapsed_inc;
				end
			end
			ACT_CURRENT: begin
				prev_cur_d = cur;
				if (diff > cfg.threshold) begin
					interval_d = FAST_MS;
					stable_d   = '0;
				end else if (stable_inc >= STABLE_SAMPLES) begin
					interval_d = backoff;
					stable_d   = '0;
				end else begin
					stable_d = stable_inc;
				end
			end
			ACT_STATUS: begin
				prev_fc_d = item.fast_charge_on;
				prev_p1_d = item.path_one_online;
				prev_p2_d = item.path_two_online;
				if (status_changed) begin
					interval_d = FAST_MS;
					stable_d   = '0;
				end
			end
			default: begin
				interval_d = FAST_MS;
				stable_d   = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= FAST_MS;
			elapsed_q  <= '0;
			stable_q   <= '0;
			prev_cur_q <= '0;
			prev_fc_q  <= 1'b0;
			prev_p1_q  <= 1'b0;
			prev_p2_q  <= 1'b0;
		end else if (fire) begin
			interval_q <= interval_d;
			elapsed_q  <= elapsed_d;
			stable_q   <= stable_d;
			prev_cur_q <= prev_cur_d;
			prev_fc_q  <= prev_fc_d;
			prev_p1_q  <= prev_p1_d;
			prev_p2_q  <= prev_p2_d;
		end
	end

	assign result.scan_due    = due;
	assign result.interval_ms = interval_d;

endmodule

// File: rtl/core/adaptive_poll_interval_backoff_unit.sv
// Top level of the adaptive poll interval backoff unit: input and result registers.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------------
//  in       | in_valid / in_ready    | action, current_ma, fast_charge_on,
//           |                        | path_one_online, path_two_online
//  out      | out_valid / out_ready  | scan_due, interval_ms
//  cfg      | cfg_we (no wait)       | cfg_index, cfg_data
//
// One item per cycle while the output does not stall; out_valid rises once the item has passed
// the input register and been captured in the result register, and the output transfer follows.
// Latency is set by the input register and the result register around the scheduler.
// Reset clears all state to the fast 200 ms interval and empties both registers.
// A stalled output holds the result register; the input register then fills and
// in_ready drops until out_ready returns.
module adaptive_poll_interval_backoff_unit
	import apib_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            action,
	input  logic signed [CUR_W-1:0] current_ma,
	input  logic                  fast_charge_on,
	input  logic                  path_one_online,
	input  logic                  path_two_online,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  scan_due,
	output logic [INTV_W-1:0]     interval_ms,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t result;
	result_t result_s2;
	logic    valid_s2;
	logic    take_s2;
	logic    fire;

	assign take_s2  = !valid_s2 || out_ready;
	assign fire     = valid_s1 && take_s2;
	assign in_ready = !valid_s1 || take_s2;

	apib_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	apib_sched u_sched (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (take_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.action          <= action_t'(action);
			item_s1.current_ma      <= current_ma;
			item_s1.fast_charge_on  <= fast_charge_on;
			item_s1.path_one_online <= path_one_online;
			item_s1.path_two_online <= path_two_online;
		end
		if (fire) begin
			result_s2 <= result;
		end
	end

	assign out_valid   = valid_s2;
	assign scan_due    = result_s2.scan_due;
	assign interval_ms = result_s2.interval_ms;

endmodule

// File: dv/tb_adaptive_poll_interval_backoff_unit.sv
// Self-checking testbench for the adaptive poll interval backoff unit.
`timescale 1ns / 1ps

module tb_adaptive_poll_interval_backoff_unit;
	import apib_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] action = '0;
	logic signed [CUR_W-1:0] current_ma = '0;
	logic fast_charge_on = 1'b0;
	logic path_one_online = 1'b0;
	logic path_two_online = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic scan_due;
	logic [INTV_W-1:0] interval_ms;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	always #5 clk = ~clk;

	adaptive_poll_interval_backoff_unit u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.action          (action),
		.current_ma      (current_ma),
		.fast_charge_on  (fast_charge_on),
		.path_one_online (path_one_online),
		.path_two_online (path_two_online),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.scan_due        (scan_due),
		.interval_ms     (interval_ms),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	item_t   pending_items[$];
	result_t sched_results_q[$];
	item_t   held_item;
	result_t next_expected;

	int issued = 0;
	int checked = 0;
	int mismatches = 0;
	int send_idle_pct = 8;
	int recv_idle_pct = 70;
	int unsigned cycle_count = 0;

	// scheduler mirror
	logic [THR_W-1:0]    cfg_threshold = THR_RESET;
	logic [FACTOR_W-1:0] cfg_factor = FACTOR_RESET;
	logic [INTV_W-1:0]   sched_interval = FAST_MS;
	logic [INTV_W-1:0]   sched_elapsed = '0;
	logic [STABLE_W-1:0] sched_stable = '0;
	logic [CUR_W-1:0]    last_current = '0;
	logic                last_fast_charge = 1'b0;
	logic                last_path_one = 1'b0;
	logic                last_path_two = 1'b0;

	// generator-side view of the last sample values
	int         gen_current = 0;
	logic [2:0] gen_status = '0;

	function automatic void restart_fast();
		sched_interval = FAST_MS;
		sched_stable = '0;
	endfunction

	function automatic result_t predict_schedule(item_t it);
		result_t r;
		logic [CUR_W-1:0] cur;
		logic [CUR_W-1:0] diff;
		logic [PROD_W-1:0] prod;
		r.scan_due = 1'b0;
		case (it.action)
			ACT_TICK: begin
				if (sched_elapsed < ELAPSED_MAX)
					sched_elapsed = sched_elapsed + 1'b1;
				if (sched_elapsed >= sched_interval) begin
					r.scan_due = 1'b1;
					sched_elapsed = '0;
				end
			end
			ACT_CURRENT: begin
				cur = it.current_ma[CUR_W-1] ? '0 : it.current_ma;
				diff = (cur > last_current) ? cur - last_current : last_current - cur;
				if (diff > cfg_threshold) begin
					restart_fast();
				end else begin
					sched_stable = sched_stable + 1'b1;
					if (sched_stable >= STABLE_SAMPLES) begin
						prod = (PROD_W'(sched_interval) * PROD_W'(cfg_factor)) >> FRAC_W;
						if (prod < PROD_W'(FAST_MS))
							sched_interval = FAST_MS;
						else if (prod > PROD_W'(SLOW_MS))
							sched_interval = SLOW_MS;
						else
							sched_interval = prod[INTV_W-1:0];
						sched_stable = '0;
					end
				end
				last_current = cur;
			end
			ACT_STATUS: begin
				if (it.fast_charge_on != last_fast_charge ||
				    it.path_one_online != last_path_one ||
				    it.path_two_online != last_path_two)
					restart_fast();
				last_fast_charge = it.fast_charge_on;
				last_path_one = it.path_one_online;
				last_path_two = it.path_two_online;
			end
			default: begin
				restart_fast();
			end
		endcase
		r.interval_ms = sched_interval;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int want, input int got);
		if (mismatches < 100)
			$display("mismatch on %s at result %0d: expected %0d, got %0d",
				what, checked, want, got);
		mismatches++;
	endtask

	task automatic queue_item(input action_t a, input logic [CUR_W-1:0] c,
	                          input logic [2:0] st);
		item_t it;
		it.action = a;
		it.current_ma = c;
		it.fast_charge_on = st[2];
		it.path_one_online = st[1];
		it.path_two_online = st[0];
		if (a == ACT_CURRENT)
			gen_current = c[CUR_W-1] ? 0 : int'(c);
		if (a == ACT_STATUS)
			gen_status = st;
		pending_items.push_back(it);
		issued++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		if (idx == CFG_THRESHOLD)
			cfg_threshold = data[THR_W-1:0];
		else
			cfg_factor = data[FACTOR_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		while (checked != issued)
			@(posedge clk);
	endtask

	task automatic queue_random(input int n);
		int made;
		int kind;
		int len;
		int lim;
		int d;
		int nc;
		logic [CUR_W-1:0] c;
		made = 0;
		while (made < n) begin
			kind = $urandom_range(0, 99);
			if (kind < 30) begin
				len = $urandom_range(3, 12);
				repeat (len) begin
					lim = (cfg_threshold > 32767) ? 32767 : int'(cfg_threshold);
					d = $urandom_range(0, lim);
					nc = $urandom_range(0, 1) ? gen_current + d : gen_current - d;
					if (nc > 32767)
						nc = gen_current - d;
					if (nc < 0)
						c = 16'h8000 | CUR_W'($urandom);
					else
						c = CUR_W'(nc);
					queue_item(ACT_CURRENT, c, 3'($urandom));
				end
				made += len;
			end else if (kind < 55) begin
				len = ($urandom_range(0, 99) < 8) ? $urandom_range(180, 260)
				                                  : $urandom_range(1, 40);
				repeat (len)
					queue_item(ACT_TICK, CUR_W'($urandom), 3'($urandom));
				made += len;
			end else if (kind < 67) begin
				queue_item(ACT_STATUS, CUR_W'($urandom),
					$urandom_range(0, 1) ? gen_status : 3'($urandom));
				made++;
			end else if (kind < 72) begin
				queue_item(ACT_FORCE, CUR_W'($urandom), 3'($urandom));
				made++;
			end else if (kind < 90) begin
				queue_item(action_t'($urandom_range(0, 3)), CUR_W'($urandom), 3'($urandom));
				made++;
			end else begin
				queue_item(ACT_CURRENT, CUR_W'($urandom_range(0, 32767)), 3'($urandom));
				made++;
			end
		end
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sched_results_q.push_back(predict_schedule(held_item));
			if (!in_valid || in_ready) begin
				if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					held_item = pending_items.pop_front();
					in_valid <= 1'b1;
					action <= held_item.action;
					current_ma <= held_item.current_ma;
					fast_charge_on <= held_item.fast_charge_on;
					path_one_online <= held_item.path_one_online;
					path_two_online <= held_item.path_two_online;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (sched_results_q.size() == 0) begin
					report_mismatch("result with nothing pending", 0, int'(interval_ms));
				end else begin
					next_expected = sched_results_q.pop_front();
					if (scan_due !== next_expected.scan_due)
						report_mismatch("scan_due", int'(next_expected.scan_due), int'(scan_due));
					if (interval_ms !== next_expected.interval_ms)
						report_mismatch("interval_ms", int'(next_expected.interval_ms),
							int'(interval_ms));
					checked++;
				end
			end
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: threshold 50, factor 2.0
		queue_item(ACT_TICK, '0, 3'b000);
		queue_item(ACT_CURRENT, 16'h7fff, 3'b000);
		queue_item(ACT_CURRENT, 16'h8000, 3'b000);
		queue_item(ACT_CURRENT, 16'hffff, 3'b000);
		queue_item(ACT_CURRENT, 16'd50, 3'b000);
		queue_item(ACT_CURRENT, 16'd0, 3'b000);
		queue_item(ACT_CURRENT, 16'd25, 3'b000);
		queue_item(ACT_CURRENT, 16'd30, 3'b000);
		queue_item(ACT_CURRENT, 16'd81, 3'b000);
		repeat (5) queue_item(ACT_CURRENT, 16'd81, 3'b000);
		queue_item(ACT_CURRENT, 16'd100, 3'b000);
		queue_item(ACT_CURRENT, 16'd131, 3'b000);
		repeat (3) queue_item(ACT_CURRENT, 16'd131, 3'b000);
		queue_item(ACT_TICK, 16'hffff, 3'b111);
		queue_item(ACT_STATUS, '0, 3'b111);
		queue_item(ACT_STATUS, '0, 3'b111);
		queue_item(ACT_STATUS, '0, 3'b011);
		queue_item(ACT_STATUS, '0, 3'b001);
		queue_item(ACT_STATUS, '0, 3'b000);
		queue_item(ACT_FORCE, 16'h8000, 3'b111);
		wait_drained();

		write_reg(CFG_THRESHOLD, 16'd0);
		write_reg(CFG_FACTOR, 16'd256);
		queue_random(258);
		wait_drained();

		write_reg(CFG_THRESHOLD, 16'hffff);
		write_reg(CFG_FACTOR, 16'd4095);
		queue_random(258);
		wait_drained();

		send_idle_pct = 70;
		recv_idle_pct = 8;
		write_reg(CFG_THRESHOLD, CFG_DATA_W'($urandom_range(20, 400)));
		write_reg(CFG_FACTOR, CFG_DATA_W'($urandom_range(256, 4095)));
		queue_random(258);
		wait_drained();

		// factor below 1.0: interval can only shrink toward the floor
		write_reg(CFG_THRESHOLD, CFG_DATA_W'($urandom));
		write_reg(CFG_FACTOR, CFG_DATA_W'($urandom_range(0, 255)));
		queue_random(258);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(CFG_THRESHOLD, THR_RESET);
		write_reg(CFG_FACTOR, FACTOR_RESET);
		queue_random(258);
		wait_drained();

		write_reg(CFG_THRESHOLD, CFG_DATA_W'($urandom_range(0, 2000)));
		write_reg(CFG_FACTOR, CFG_DATA_W'($urandom_range(0, 4095)));
		queue_random(258);
		wait_drained();

		repeat (8) @(posedge clk);
		if (mismatches == 0 && sched_results_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
